>>> hw/rtl/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl_pkg: shared types and constants of the sliding-window rate limiter
// Field widths, divider step counts, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

	// Field widths
	localparam int unsigned TIME_W   = 48;
	localparam int unsigned AMOUNT_W = 16;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CFG_IDX_W = 4;

	// Divider work register and step counter
	localparam int unsigned NUM_W = 2 * WORD_W;
	localparam int unsigned CNT_W = 6;

	// Steps of the shared divider for a timestamp and for the weighted product
	localparam logic [CNT_W-1:0] TIME_STEPS_M1 = CNT_W'(TIME_W - 1);
	localparam logic [CNT_W-1:0] PROD_STEPS_M1 = CNT_W'(NUM_W - 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_THRESHOLD = CFG_IDX_W'(1);

	// Configuration reset values
	localparam logic [WORD_W-1:0] WINDOW_LENGTH_RST   = WORD_W'(10);
	localparam logic [WORD_W-1:0] LIMIT_THRESHOLD_RST = WORD_W'(3);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_T,
		ST_DIV_L,
		ST_UPDATE,
		ST_MUL,
		ST_DIV_P,
		ST_DONE
	} state_t;

endpackage : swrl_pkg

`default_nettype wire

>>> hw/rtl/swrl_if.sv
// ----------------------------------------------------------------------------
// swrl_if: request channels of the sliding-window rate limiter
// Event channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Event request: timestamp and amount
interface swrl_evt_if;
	logic                           valid;
	logic                           ready;
	logic [swrl_pkg::TIME_W-1:0]    event_time;
	logic [swrl_pkg::AMOUNT_W-1:0]  amount;

	modport source (output valid, output event_time, output amount, input ready);
	modport sink   (input valid, input event_time, input amount, output ready);
endinterface : swrl_evt_if

// Result request: estimate and flags
interface swrl_res_if;
	logic                         valid;
	logic                         ready;
	logic [swrl_pkg::WORD_W-1:0]  estimate;
	logic                         over_limit;
	logic                         ignored;

	modport source (output valid, output estimate, output over_limit, output ignored,
		input ready);
	modport sink   (input valid, input estimate, input over_limit, input ignored,
		output ready);
endinterface : swrl_res_if

// Configuration write request: register index and data
interface swrl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [swrl_pkg::CFG_IDX_W-1:0]  index;
	logic [swrl_pkg::WORD_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface : swrl_cfg_if

`default_nettype wire

>>> hw/rtl/sliding_window_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_top: two-slot sliding-window event counter
// Counts events per window, reports a weighted estimate and an over-limit flag.
// ----------------------------------------------------------------------------
// Usage:
//   evt  - event requests (event_time, amount). One result request per event.
//   res  - result requests (estimate, over_limit, ignored).
//   cfg  - register writes: index 0 window_length, index 1 limit_threshold;
//          other indexes are dropped. Taken only while the sequencer is idle.
// Timing: one restoring divider, one quotient bit per cycle, does the
//   divisions: event time / length (ST_DIV_T), latest time / length
//   (ST_DIV_L), then slot product / length (ST_DIV_P). The slot update
//   (ST_UPDATE) and the 32x32 multiply (ST_MUL) come between the second
//   and third division, and the final add is done in ST_DONE. A new event
//   is taken only once the result is loaded and the sequencer is idle.
// Stall: the result register holds its request while res.ready is low; the
//   next event is still accepted and worked on, and waits in the last state
//   until the result register frees up.
// Reset: arst_n clears both slots, the latest time, the result valid flag and
//   restores window_length = 10 and limit_threshold = 3. No clearing pass.
// A window_length of zero acts as one.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_limiter_top (
	input  wire         clk,
	input  wire         arst_n,
	swrl_evt_if.sink    evt,
	swrl_res_if.source  res,
	swrl_cfg_if.sink    cfg
);
	import swrl_pkg::*;

	// Sequencer and architectural state
	state_t               state_q, state_d;
	logic [WORD_W-1:0]    win_len_q;
	logic [WORD_W-1:0]    threshold_q;
	logic [WORD_W-1:0]    slot0_q, slot1_q;
	logic [TIME_W-1:0]    latest_q;

	// Captured event
	logic [TIME_W-1:0]    t_q;
	logic [AMOUNT_W-1:0]  amt_q;

	// Shared divider
	logic [NUM_W-1:0]     num_q;
	logic [WORD_W-1:0]    rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_W:0]      shifted;
	logic                 ge;
	logic [WORD_W:0]      rem_n;
	logic [NUM_W-1:0]     num_n;
	logic                 last_step;

	// Division results and estimate terms
	logic [TIME_W-1:0]    wq_q, cq_q;
	logic [WORD_W-1:0]    wr_q, cr_q;
	logic                 cur_q;
	logic                 ign_q;
	logic [WORD_W-1:0]    weight_q;

	// Result register
	logic                 res_valid_q;
	logic [WORD_W-1:0]    res_est_q;
	logic                 res_over_q;
	logic                 res_ign_q;

	// Combinational helpers
	logic [WORD_W-1:0]    len_eff;
	logic                 evt_fire;
	logic                 res_load;
	logic [TIME_W:0]      w_ext, c_ext;
	logic                 too_old, jump, next_win;
	logic                 use_t;
	logic [WORD_W-1:0]    slot_idx, slot_sum;
	logic [WORD_W:0]      sum_ext;
	logic [WORD_W-1:0]    rem_sel;
	logic [WORD_W-1:0]    slot_prev, slot_cur;
	logic [NUM_W-1:0]     prod;
	logic [WORD_W:0]      total;
	logic [WORD_W-1:0]    est;

	// Effective window length
	assign len_eff = (win_len_q == '0) ? WORD_W'(1) : win_len_q;

	// Handshakes
	assign evt.ready = (state_q == ST_IDLE);
	assign cfg.ready = (state_q == ST_IDLE);
	assign evt_fire  = evt.valid && evt.ready;
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// Divider step: one quotient bit
	assign shifted   = {rem_q, num_q[NUM_W-1]};
	assign ge        = (shifted >= {1'b0, len_eff});
	assign rem_n     = ge ? (shifted - {1'b0, len_eff}) : shifted;
	assign num_n     = {num_q[NUM_W-2:0], ge};
	assign last_step = (cnt_q == '0);

	// Window comparison
	assign w_ext    = {1'b0, wq_q};
	assign c_ext    = {1'b0, cq_q};
	assign too_old  = (w_ext + (TIME_W+1)'(1)) < c_ext;
	assign jump     = w_ext >= (c_ext + (TIME_W+1)'(2));
	assign next_win = (w_ext == (c_ext + (TIME_W+1)'(1)));
	assign use_t    = !too_old && (t_q > latest_q);

	// Saturating slot add
	assign slot_idx = wq_q[0] ? slot1_q : slot0_q;
	assign sum_ext  = {1'b0, slot_idx} + {(WORD_W+1-AMOUNT_W)'(0), amt_q};
	assign slot_sum = sum_ext[WORD_W] ? '1 : sum_ext[WORD_W-1:0];

	// Remainder of the new latest time
	assign rem_sel = use_t ? wr_q : cr_q;

	// Weighting multiply and final add
	assign slot_prev = cur_q ? slot0_q : slot1_q;
	assign slot_cur  = cur_q ? slot1_q : slot0_q;
	assign prod      = slot_prev * weight_q;
	assign total     = {1'b0, slot_cur} + {1'b0, num_q[WORD_W-1:0]};
	assign est       = total[WORD_W] ? '1 : total[WORD_W-1:0];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_fire) state_d = ST_DIV_T;
			end
			ST_DIV_T: begin
				if (last_step) state_d = ST_DIV_L;
			end
			ST_DIV_L: begin
				if (last_step) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_DIV_P;
			end
			ST_DIV_P: begin
				if (last_step) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WINDOW_LENGTH_RST;
			threshold_q <= LIMIT_THRESHOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			priority if (cfg.index == REG_WINDOW_LENGTH) begin
				win_len_q <= cfg.data;
			end else if (cfg.index == REG_LIMIT_THRESHOLD) begin
				threshold_q <= cfg.data;
			end
		end
	end

	// Slots and latest time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_q  <= '0;
			slot1_q  <= '0;
			latest_q <= '0;
		end else if (state_q == ST_UPDATE && !too_old) begin
			if (wq_q[0]) begin
				slot1_q <= (jump || next_win) ? WORD_W'(amt_q) : slot_sum;
				if (jump) slot0_q <= '0;
			end else begin
				slot0_q <= (jump || next_win) ? WORD_W'(amt_q) : slot_sum;
				if (jump) slot1_q <= '0;
			end
			if (use_t) latest_q <= t_q;
		end
	end

	// Datapath: event capture, shared divider, estimate terms
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (evt_fire) begin
					t_q   <= evt.event_time;
					amt_q <= evt.amount;
					num_q <= {evt.event_time, (NUM_W-TIME_W)'(0)};
					rem_q <= '0;
					cnt_q <= TIME_STEPS_M1;
				end
			end
			ST_DIV_T: begin
				if (last_step) begin
					wq_q  <= num_n[TIME_W-1:0];
					wr_q  <= rem_n[WORD_W-1:0];
					num_q <= {latest_q, (NUM_W-TIME_W)'(0)};
					rem_q <= '0;
					cnt_q <= TIME_STEPS_M1;
				end else begin
					num_q <= num_n;
					rem_q <= rem_n[WORD_W-1:0];
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_DIV_L: begin
				if (last_step) begin
					cq_q <= num_n[TIME_W-1:0];
					cr_q <= rem_n[WORD_W-1:0];
				end else begin
					num_q <= num_n;
					rem_q <= rem_n[WORD_W-1:0];
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_UPDATE: begin
				ign_q    <= too_old;
				cur_q    <= use_t ? wq_q[0] : cq_q[0];
				weight_q <= len_eff - rem_sel - WORD_W'(1);
			end
			ST_MUL: begin
				num_q <= prod;
				rem_q <= '0;
				cnt_q <= PROD_STEPS_M1;
			end
			ST_DIV_P: begin
				num_q <= num_n;
				rem_q <= rem_n[WORD_W-1:0];
				if (!last_step) cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_est_q  <= est;
			res_over_q <= (est > threshold_q);
			res_ign_q  <= ign_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.estimate   = res_est_q;
	assign res.over_limit = res_over_q;
	assign res.ignored    = res_ign_q;

	// The latest time only moves forward
	a_latest_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> latest_q >= $past(latest_q))
		else $error("latest time moved backward");

	// Partial remainder stays below the divisor while dividing
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_T || state_q == ST_DIV_L || state_q == ST_DIV_P)
			|-> rem_q < len_eff)
		else $error("divider remainder out of range");

	// The weight is below the window length
	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> weight_q < len_eff)
		else $error("weight not below window length");

	// A new result only comes out of the final state
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final state");

endmodule : sliding_window_rate_limiter_top

`default_nettype wire
